/* rtl/core/cae_pkg.sv */
// ----------------------------------------------------------------------------
// cae_pkg
// shared types, constants and the microcode rom of the chen attractor stepper
// ----------------------------------------------------------------------------
package cae_pkg;

    localparam int unsigned PC_W   = 5;
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 32;
    localparam int unsigned OUT_DW = 48;
    localparam int unsigned IN_DW  = 8;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_SPEED = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_A     = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_B     = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_C     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_INITX = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_INITY = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_INITZ = 3'd6;

    // reset values
    localparam logic [15:0]        RST_SPEED = 16'd0;
    localparam logic [15:0]        RST_A     = 16'd32768;
    localparam logic [15:0]        RST_B     = 16'd32768;
    localparam logic [15:0]        RST_C     = 16'd65535;
    localparam logic signed [31:0] RST_INITX = 32'sd4194304;
    localparam logic signed [31:0] RST_INITY = 32'sd0;
    localparam logic signed [31:0] RST_INITZ = 32'sd0;

    // arithmetic constants
    localparam logic [21:0] STEP_K     = 22'd2415919;
    localparam logic [28:0] A_BASE     = 29'd134217728;
    localparam logic [25:0] B_BASE     = 26'd4194304;
    localparam logic [26:0] C_BASE     = 27'd117440512;
    localparam logic [32:0] OFFSET_Q22 = 33'd75497472;
    localparam logic [23:0] T_MAX      = 24'd589823;
    localparam logic [19:0] RECIP9     = 20'd932068;

    typedef enum logic [4:0] {
        MUL_NONE, MUL_H, MUL_AXY, MUL_CAX, MUL_XZ, MUL_CY, MUL_XY, MUL_BZ,
        MUL_DXH, MUL_DXL, MUL_DYH, MUL_DYL, MUL_DZH, MUL_DZL,
        MUL_SX, MUL_SY, MUL_SZ
    } t_mul;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_LDSH
    } t_acc;

    typedef enum logic [3:0] {
        WR_NONE, WR_H, WR_DX, WR_DY, WR_DZ, WR_NX, WR_NY, WR_NZ, WR_INIT
    } t_wr;

    typedef enum logic [1:0] {
        CAP_NONE, CAP_X, CAP_Y
    } t_cap;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_BRST, SEQ_DONE
    } t_seq;

    typedef struct packed {
        t_mul            mul;
        t_acc            acc;
        t_wr             wr;
        t_cap            cap;
        t_seq            seq;
        logic [PC_W-1:0] tgt;
    } t_ctl;

    localparam t_ctl CTL_NOP = '{mul: MUL_NONE, acc: ACC_NONE, wr: WR_NONE,
                                 cap: CAP_NONE, seq: SEQ_NEXT, tgt: '0};

    localparam logic [PC_W-1:0] PC_RESTART = 5'd17;

    function automatic t_ctl ucode(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = CTL_NOP;
        unique case (pc)
            5'd0: begin
                w.mul = MUL_H;   w.seq = SEQ_BRST; w.tgt = PC_RESTART;
            end
            5'd1:  begin w.mul = MUL_AXY; w.acc = ACC_LOAD; end
            5'd2:  begin w.mul = MUL_CAX; w.acc = ACC_LOAD; w.wr = WR_H;  end
            5'd3:  begin w.mul = MUL_XZ;  w.acc = ACC_LOAD; w.wr = WR_DX; end
            5'd4:  begin w.mul = MUL_CY;  w.acc = ACC_SUB;  end
            5'd5:  begin w.mul = MUL_XY;  w.acc = ACC_ADD;  end
            5'd6:  begin w.mul = MUL_BZ;  w.acc = ACC_LOAD; w.wr = WR_DY; end
            5'd7:  begin w.mul = MUL_DXH; w.acc = ACC_SUB;  end
            5'd8:  begin w.mul = MUL_DXL; w.acc = ACC_LDSH; w.wr = WR_DZ; end
            5'd9:  begin w.mul = MUL_DYH; w.acc = ACC_ADD;  end
            5'd10: begin w.mul = MUL_DYL; w.acc = ACC_LDSH; w.wr = WR_NX; end
            5'd11: begin w.mul = MUL_DZH; w.acc = ACC_ADD;  end
            5'd12: begin w.mul = MUL_DZL; w.acc = ACC_LDSH; w.wr = WR_NY; end
            5'd13: begin w.mul = MUL_SX;  w.acc = ACC_ADD;  end
            5'd14: begin w.mul = MUL_SY;  w.wr = WR_NZ; w.cap = CAP_X; end
            5'd15: begin w.mul = MUL_SZ;  w.cap = CAP_Y; end
            5'd16: begin w.seq = SEQ_DONE; end
            5'd17: begin w.wr = WR_INIT; end
            5'd18: begin w.mul = MUL_SX; end
            5'd19: begin w.mul = MUL_SY; w.cap = CAP_X; end
            5'd20: begin w.mul = MUL_SZ; w.cap = CAP_Y; end
            5'd21: begin w.seq = SEQ_DONE; end
            default: begin w.seq = SEQ_DONE; end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/cae_datapath.sv */
// ----------------------------------------------------------------------------
// cae_datapath
// shared multiplier, accumulator and state registers driven by control words
// ----------------------------------------------------------------------------
module cae_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cae_pkg::t_ctl              i_ctl,
    input  logic [15:0]                i_speed,
    input  logic [15:0]                i_ka,
    input  logic [15:0]                i_kb,
    input  logic [15:0]                i_kc,
    input  logic signed [31:0]         i_init_x,
    input  logic signed [31:0]         i_init_y,
    input  logic signed [31:0]         i_init_z,
    output logic [cae_pkg::OUT_DW-1:0] o_res    // out_x, out_y, out_z
);

    logic signed [31:0] r_px, r_py, r_pz;
    logic        [21:0] r_h;
    logic signed [41:0] r_dx, r_dy, r_dz;
    logic signed [65:0] r_acc;
    logic signed [65:0] r_prod;
    logic        [15:0] r_ox, r_oy;

    logic        [28:0] a_val;
    logic        [25:0] b_val;
    logic        [26:0] c_val;
    logic        [18:0] kb5;
    logic signed [29:0] cma;
    logic signed [32:0] ymx;
    logic        [19:0] tx, ty, tz;
    logic signed [32:0] op_a, op_b;
    logic signed [65:0] prod_c;
    logic signed [65:0] n_acc;

    function automatic logic [19:0] scale_op(input logic signed [31:0] v);
        logic signed [32:0] s;
        s = {v[31], v} + $signed(cae_pkg::OFFSET_Q22);
        if (s[32])
            return 20'd0;
        else if (s[31:8] > cae_pkg::T_MAX)
            return cae_pkg::T_MAX[19:0];
        else
            return s[27:8];
    endfunction

    function automatic logic signed [31:0] step_sat(input logic signed [31:0] p,
                                                   input logic signed [65:0] d);
        logic signed [36:0] sum;
        sum = {{5{p[31]}}, p} + {d[63], d[63:28]};
        if (sum > 37'sh007FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (sum < -37'sh0080000000)
            return 32'sh80000000;
        else
            return sum[31:0];
    endfunction

    assign kb5   = {3'b0, i_kb} + {1'b0, i_kb, 2'b0};
    assign a_val = cae_pkg::A_BASE + {3'b0, i_ka, 10'b0};
    assign b_val = cae_pkg::B_BASE + {1'b0, kb5, 6'b0};
    assign c_val = cae_pkg::C_BASE - {3'b0, i_kc, 8'b0};
    assign cma   = $signed({3'b0, c_val}) - $signed({1'b0, a_val});
    assign ymx   = {r_py[31], r_py} - {r_px[31], r_px};
    assign tx    = scale_op(r_px);
    assign ty    = scale_op(r_py);
    assign tz    = scale_op(r_pz);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_ctl.mul)
            cae_pkg::MUL_H:   begin op_a = {17'b0, i_speed}; op_b = {11'b0, cae_pkg::STEP_K}; end
            cae_pkg::MUL_AXY: begin op_a = {4'b0, a_val};    op_b = ymx; end
            cae_pkg::MUL_CAX: begin op_a = {{3{cma[29]}}, cma}; op_b = {r_px[31], r_px}; end
            cae_pkg::MUL_XZ:  begin op_a = {r_px[31], r_px}; op_b = {r_pz[31], r_pz}; end
            cae_pkg::MUL_CY:  begin op_a = {6'b0, c_val};    op_b = {r_py[31], r_py}; end
            cae_pkg::MUL_XY:  begin op_a = {r_px[31], r_px}; op_b = {r_py[31], r_py}; end
            cae_pkg::MUL_BZ:  begin op_a = {7'b0, b_val};    op_b = {r_pz[31], r_pz}; end
            cae_pkg::MUL_DXH: begin op_a = {{12{r_dx[41]}}, r_dx[41:21]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_DXL: begin op_a = {12'b0, r_dx[20:0]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_DYH: begin op_a = {{12{r_dy[41]}}, r_dy[41:21]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_DYL: begin op_a = {12'b0, r_dy[20:0]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_DZH: begin op_a = {{12{r_dz[41]}}, r_dz[41:21]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_DZL: begin op_a = {12'b0, r_dz[20:0]}; op_b = {11'b0, r_h}; end
            cae_pkg::MUL_SX:  begin op_a = {13'b0, tx}; op_b = {13'b0, cae_pkg::RECIP9}; end
            cae_pkg::MUL_SY:  begin op_a = {13'b0, ty}; op_b = {13'b0, cae_pkg::RECIP9}; end
            cae_pkg::MUL_SZ:  begin op_a = {13'b0, tz}; op_b = {13'b0, cae_pkg::RECIP9}; end
            default:          begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod_c = op_a * op_b;

    always_comb begin
        n_acc = r_acc;
        unique case (i_ctl.acc)
            cae_pkg::ACC_LOAD: n_acc = r_prod;
            cae_pkg::ACC_ADD:  n_acc = r_acc + r_prod;
            cae_pkg::ACC_SUB:  n_acc = r_acc - r_prod;
            cae_pkg::ACC_LDSH: n_acc = {r_prod[44:0], 21'b0};
            default:           n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul != cae_pkg::MUL_NONE) begin
            r_prod <= prod_c;
        end
        r_acc <= n_acc;
        unique case (i_ctl.wr)
            cae_pkg::WR_H:  r_h  <= r_acc[37:16];
            cae_pkg::WR_DX: r_dx <= r_acc[63:22];
            cae_pkg::WR_DY: r_dy <= r_acc[63:22];
            cae_pkg::WR_DZ: r_dz <= r_acc[63:22];
            default: ;
        endcase
        unique case (i_ctl.cap)
            cae_pkg::CAP_X: r_ox <= r_prod[38:23];
            cae_pkg::CAP_Y: r_oy <= r_prod[38:23];
            default: ;
        endcase
    end

    // point state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= cae_pkg::RST_INITX;
            r_py <= cae_pkg::RST_INITY;
            r_pz <= cae_pkg::RST_INITZ;
        end else begin
            unique case (i_ctl.wr)
                cae_pkg::WR_NX: r_px <= step_sat(r_px, r_acc);
                cae_pkg::WR_NY: r_py <= step_sat(r_py, r_acc);
                cae_pkg::WR_NZ: r_pz <= step_sat(r_pz, r_acc);
                cae_pkg::WR_INIT: begin
                    r_px <= i_init_x;
                    r_py <= i_init_y;
                    r_pz <= i_init_z;
                end
                default: ;
            endcase
        end
    end

    assign o_res = {r_prod[38:23], r_oy, r_ox};

endmodule

/* rtl/core/chen_attractor_euler_step.sv */
// ----------------------------------------------------------------------------
// chen_attractor_euler_step
// chen attractor oscillator, one forward euler step or one restart per input transaction
// ----------------------------------------------------------------------------
// input stream: one transaction per tick, tdata bit 0 is restart (1 reloads
// the start point from init_x/y/z, 0 advances one euler step)
// output stream: one transaction per input, x, y and z scaled to q0.16
// configuration: write port, index 0..6 = speed, a, b, c, init_x/y/z
// a microcode rom steps one shared 33x33 multiplier and an accumulator;
// an euler step runs control words 0 to 16, a restart word 0 and then 17 to
// 21, and the result is valid on the cycle after the last control word
// the block takes no new item until the sequencer is through with the last,
// as all of its products pass through the single multiplier
// s_axis_tready is high while the sequencer is idle; the next item is taken
// while a finished result still waits in the output register
// when the receiver stalls, the sequencer holds on its last word until the
// output register frees
// reset restores the control state, the configuration registers and the point to their reset values
// ----------------------------------------------------------------------------
module chen_attractor_euler_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cae_pkg::IN_DW-1:0]   s_axis_tdata,   // restart, zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [cae_pkg::OUT_DW-1:0]  m_axis_tdata,   // out_x, out_y, out_z
    input  logic                        i_cfg_we,
    input  logic [cae_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [cae_pkg::CFG_DW-1:0]  i_cfg_wdata
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic [cae_pkg::PC_W-1:0]       r_pc, n_pc;
    logic                           r_restart, n_restart;
    logic                           r_m_valid, n_m_valid;
    logic [cae_pkg::OUT_DW-1:0]     r_m_data;
    logic [15:0]                    r_speed, r_ka, r_kb, r_kc;
    logic signed [31:0]             r_init_x, r_init_y, r_init_z;

    cae_pkg::t_ctl                  word;
    cae_pkg::t_ctl                  ctl;
    logic                           in_acc;
    logic                           out_free;
    logic                           run_en;
    logic                           finish;
    logic [cae_pkg::OUT_DW-1:0]     res;

    assign word     = cae_pkg::ucode(r_pc);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign run_en   = (r_state == ST_RUN) &&
                      ((word.seq != cae_pkg::SEQ_DONE) || out_free);
    assign finish   = run_en && (word.seq == cae_pkg::SEQ_DONE);
    assign ctl      = run_en ? word : cae_pkg::CTL_NOP;

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_restart = r_restart;
        n_m_valid = r_m_valid;
        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        if (finish) begin
            n_m_valid = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state   = ST_RUN;
                    n_pc      = '0;
                    n_restart = s_axis_tdata[0];
                end
            end
            ST_RUN: begin
                if (run_en) begin
                    unique case (word.seq)
                        cae_pkg::SEQ_DONE: n_state = ST_IDLE;
                        cae_pkg::SEQ_BRST: n_pc = r_restart ? word.tgt : r_pc + 1'b1;
                        default:           n_pc = r_pc + 1'b1;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_restart <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_restart <= n_restart;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_m_data <= res;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= cae_pkg::RST_SPEED;
            r_ka     <= cae_pkg::RST_A;
            r_kb     <= cae_pkg::RST_B;
            r_kc     <= cae_pkg::RST_C;
            r_init_x <= cae_pkg::RST_INITX;
            r_init_y <= cae_pkg::RST_INITY;
            r_init_z <= cae_pkg::RST_INITZ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cae_pkg::CFG_SPEED: r_speed  <= i_cfg_wdata[15:0];
                cae_pkg::CFG_A:     r_ka     <= i_cfg_wdata[15:0];
                cae_pkg::CFG_B:     r_kb     <= i_cfg_wdata[15:0];
                cae_pkg::CFG_C:     r_kc     <= i_cfg_wdata[15:0];
                cae_pkg::CFG_INITX: r_init_x <= $signed(i_cfg_wdata);
                cae_pkg::CFG_INITY: r_init_y <= $signed(i_cfg_wdata);
                cae_pkg::CFG_INITZ: r_init_z <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    cae_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_speed  (r_speed),
        .i_ka     (r_ka),
        .i_kb     (r_kb),
        .i_kc     (r_kc),
        .i_init_x (r_init_x),
        .i_init_y (r_init_y),
        .i_init_z (r_init_z),
        .o_res    (res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

/* rtl/core/cae_checker.sv */
// ----------------------------------------------------------------------------
// cae_checker
// port level checks of the chen attractor stepper, bound to the top level
// ----------------------------------------------------------------------------
module cae_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [cae_pkg::OUT_DW-1:0]  m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transaction changed");

    // ready stays low right after an accepted transaction and at a later check inside the shortest program
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##4 !s_axis_tready)
        else $error("input taken again too early");

    // a new result shows up exactly when the sequencer goes idle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $rose(s_axis_tready))
        else $error("result appeared while sequencer busy");

endmodule

bind chen_attractor_euler_step cae_checker u_cae_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chen attractor euler stepper
// ----------------------------------------------------------------------------
// a scoreboard class tracks the point and knob registers in 64-bit integer
// arithmetic and predicts the normalized x/y/z of every input transaction.
// a directed burst covers knob and start-point extremes, the ignored register
// index, saturation at the q9.22 limits and the output clamp edges; random
// bursts of restart-led euler runs follow under random valid/ready gaps,
// with long receiver holds that back the block up into its input side
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
} point_q16_t;

class chen_point_scoreboard;
    localparam longint Q16_DIV = 2304;

    logic        [15:0] speed_knob = cae_pkg::RST_SPEED;
    logic        [15:0] a_knob     = cae_pkg::RST_A;
    logic        [15:0] b_knob     = cae_pkg::RST_B;
    logic        [15:0] c_knob     = cae_pkg::RST_C;
    logic signed [31:0] init_x     = cae_pkg::RST_INITX;
    logic signed [31:0] init_y     = cae_pkg::RST_INITY;
    logic signed [31:0] init_z     = cae_pkg::RST_INITZ;
    logic signed [31:0] pos_x      = cae_pkg::RST_INITX;
    logic signed [31:0] pos_y      = cae_pkg::RST_INITY;
    logic signed [31:0] pos_z      = cae_pkg::RST_INITZ;

    point_q16_t expected_points[$];
    int n_checked  = 0;
    int n_fail     = 0;
    int n_reported = 0;

    function void write_reg(logic [cae_pkg::CFG_AW-1:0] addr, logic [31:0] data);
        case (addr)
            cae_pkg::CFG_SPEED: speed_knob = data[15:0];
            cae_pkg::CFG_A:     a_knob     = data[15:0];
            cae_pkg::CFG_B:     b_knob     = data[15:0];
            cae_pkg::CFG_C:     c_knob     = data[15:0];
            cae_pkg::CFG_INITX: init_x     = data;
            cae_pkg::CFG_INITY: init_y     = data;
            cae_pkg::CFG_INITZ: init_z     = data;
            default: ;
        endcase
    endfunction

    function logic signed [31:0] sat_q22(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function logic [15:0] to_q16(logic signed [31:0] v);
        longint s;
        s = longint'(v) + longint'(cae_pkg::OFFSET_Q22);
        if (s < 0)
            return 16'd0;
        s = s / Q16_DIV;
        if (s > 65535)
            return 16'hffff;
        return s[15:0];
    endfunction

    function void note_tick(bit restart);
        longint a, b, c, h, x, y, z, dx, dy, dz;
        if (restart) begin
            pos_x = init_x;
            pos_y = init_y;
            pos_z = init_z;
        end else begin
            a  = (64'sd32 <<< 22) + (longint'(a_knob) <<< 10);
            b  = (64'sd1 <<< 22) + ((64'sd5 * longint'(b_knob)) <<< 6);
            c  = (64'sd28 <<< 22) - (longint'(c_knob) <<< 8);
            h  = (longint'(speed_knob) * longint'(cae_pkg::STEP_K)) >>> 16;
            x  = pos_x;
            y  = pos_y;
            z  = pos_z;
            dx = (a * (y - x)) >>> 22;
            dy = ((c - a) * x - x * z + c * y) >>> 22;
            dz = (x * y - b * z) >>> 22;
            pos_x = sat_q22(x + ((dx * h) >>> 28));
            pos_y = sat_q22(y + ((dy * h) >>> 28));
            pos_z = sat_q22(z + ((dz * h) >>> 28));
        end
        expected_points.push_back('{nz: to_q16(pos_z), ny: to_q16(pos_y),
                                    nx: to_q16(pos_x)});
    endfunction

    function void check_point(point_q16_t got);
        point_q16_t want;
        n_checked++;
        if (expected_points.size() == 0) begin
            n_fail++;
            if (n_reported < 10) begin
                n_reported++;
                $display("unexpected output transaction x=%h y=%h z=%h",
                         got.nx, got.ny, got.nz);
            end
            return;
        end
        want = expected_points.pop_front();
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz) begin
            n_fail++;
            if (n_reported < 10) begin
                n_reported++;
                $display("mismatch on output %0d: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                         n_checked, want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
            end
        end
    endfunction

    function int pending();
        return expected_points.size();
    endfunction
endclass

module tb_top;
    import cae_pkg::*;

    localparam int                N_TICKS     = 1950;
    localparam int                HOLD_CYCLES = 300;
    localparam int                CYCLE_LIMIT = 1500000;
    localparam logic [CFG_AW-1:0] CFG_UNUSED  = 3'd7;
    localparam logic [31:0]       Q22_MAX     = 32'h7fffffff;
    localparam logic [31:0]       Q22_MIN     = 32'h80000000;
    localparam logic [31:0]       ONE_Q22     = 32'd4194304;
    localparam logic [31:0]       EDGE_Q22    = 32'd75497472;
    localparam logic [31:0]       SPAN_Q22    = 32'd209715200;
    localparam logic [31:0]       KNOB_MAX    = 32'h0000ffff;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata  = '0;      // restart, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   m_axis_tdata;            // out_x, out_y, out_z
    logic                i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr    = '0;
    logic [CFG_DW-1:0]   i_cfg_wdata   = '0;

    chen_point_scoreboard sb = new;

    int n_ticks    = 0;
    int n_restarts = 0;
    int n_writes   = 0;
    int n_bursts   = 0;
    int n_holds    = 0;
    int n_cycles   = 0;
    bit hold_req   = 1'b0;

    chen_attractor_euler_step u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata);
    end

    // output side: random ready stretches, plus long holds on request
    initial begin
        int  stretch;
        int  r;
        logic lvl;
        stretch = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                n_holds++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                stretch = 0;
            end else if (stretch == 0) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    lvl = 1'b1;
                    stretch = $urandom_range(1, 20);
                end else if (r < 60) begin
                    lvl = 1'b1;
                    stretch = $urandom_range(50, 150);
                end else if (r < 92) begin
                    lvl = 1'b0;
                    stretch = $urandom_range(1, 3);
                end else begin
                    lvl = 1'b0;
                    stretch = $urandom_range(5, 40);
                end
                m_axis_tready <= lvl;
                stretch--;
            end else begin
                stretch--;
            end
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [31:0] rand_knob();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {$urandom_range(0, 65535), 16'h0000};
        if (r == 1)
            return {$urandom_range(0, 65535), 16'hffff};
        return $urandom();
    endfunction

    function automatic logic [31:0] rand_init();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, SPAN_Q22) - (SPAN_Q22 >> 1);
        if (r < 9)
            return $urandom();
        return $urandom_range(0, 1) ? Q22_MAX : Q22_MIN;
    endfunction

    function automatic logic [31:0] rand_reg_value(logic [CFG_AW-1:0] addr);
        case (addr)
            CFG_SPEED, CFG_A, CFG_B, CFG_C: return rand_knob();
            CFG_INITX, CFG_INITY, CFG_INITZ: return rand_init();
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        sb.write_reg(addr, data);
        n_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_tick(input bit restart, input bit calm);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DW-1){1'b0}}, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_tick(restart);
        n_ticks++;
        if (restart)
            n_restarts++;
        gap = pick_gap(calm);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_start(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        write_reg(CFG_INITX, x);
        write_reg(CFG_INITY, y);
        write_reg(CFG_INITZ, z);
    endtask

    initial begin
        int  len;
        bit  calm;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset point with zero speed, then reload of the reset start point
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        // full speed, start point at the corners; the new start point must not take
        // effect until a restart, and the unused index must change nothing
        write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_SPEED, KNOB_MAX);
        set_start(Q22_MIN, Q22_MAX, Q22_MIN);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        write_reg(CFG_A, KNOB_MAX);
        write_reg(CFG_B, KNOB_MAX);
        write_reg(CFG_C, 32'd0);
        set_start(Q22_MAX, Q22_MAX, Q22_MAX);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        drain();

        write_reg(CFG_A, 32'd0);
        write_reg(CFG_B, 32'd0);
        write_reg(CFG_C, KNOB_MAX);
        set_start(Q22_MIN, Q22_MIN, Q22_MAX);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        // output clamp edges at -18 and +18
        set_start(-EDGE_Q22, EDGE_Q22, -EDGE_Q22 - 1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        set_start(32'd0, 32'd0, 32'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        // smallest nonzero step size
        write_reg(CFG_SPEED, 32'd1);
        set_start(ONE_Q22, ONE_Q22, ONE_Q22);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();

        write_reg(CFG_SPEED, 32'd32768);
        write_reg(CFG_A, rand_knob());
        write_reg(CFG_B, rand_knob());
        write_reg(CFG_C, rand_knob());
        set_start(ONE_Q22, ONE_Q22 << 1, ONE_Q22 << 2);
        send_tick(1'b1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0);
        drain();

        // random bursts: mostly restart followed by a long euler run
        while (n_ticks < N_TICKS) begin
            for (int idx = 0; idx <= CFG_UNUSED; idx++) begin
                if ($urandom_range(0, 9) < 6)
                    write_reg(idx[CFG_AW-1:0], rand_reg_value(idx[CFG_AW-1:0]));
            end
            calm = ($urandom_range(0, 3) == 0);
            if (n_bursts % 12 == 1) begin
                hold_req = 1'b1;
                calm = 1'b1;
            end
            len = $urandom_range(15, 70);
            send_tick($urandom_range(0, 9) != 0, calm);
            repeat (len) send_tick($urandom_range(0, 32) == 0, calm);
            drain();
            n_bursts++;
        end

        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected output transactions never arrived", sb.pending());
            sb.n_fail += sb.pending();
        end

        $display("sent %0d ticks (%0d restarts) in %0d random bursts, %0d register writes, %0d long output holds",
                 n_ticks, n_restarts, n_bursts, n_writes, n_holds);
        $display("checked %0d output transactions, %0d failures", sb.n_checked, sb.n_fail);
        if (sb.n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
